// ===== rtl/mie_pkg.sv =====
// Shared types and constants for the modular inverse block.
package mie_pkg;

    // Operand width; fixed by the item fields.
    localparam int WIDTH = 31;
    // Coefficient width: signed, with headroom over the modulus.
    localparam int CW = WIDTH + 2;
    // Bit counter width for one division.
    localparam int CNT_W = $clog2(WIDTH);

    typedef struct packed {
        logic [WIDTH-1:0] value;
        logic [WIDTH-1:0] modulus;
    } t_in;

    typedef struct packed {
        logic             exists;
        logic [WIDTH-1:0] inverse;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPDATE,
        S_DONE
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load;      // capture operands, reset coefficients
        logic div_init;  // clear remainder and product
        logic div_step;  // one restoring division bit
        logic update;    // shift Euclid pair and coefficients
        logic fin;       // register the result item
    } t_dp_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic a_gt1;
        logic n_zero;
        logic m_one;
    } t_dp_sts;

endpackage

// ===== rtl/mie_ctrl.sv =====
// Controller state machine for the modular inverse block.
module mie_ctrl
    import mie_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.m_one) n_state = S_DONE;
                else if (i_sts.a_gt1 && !i_sts.n_zero) n_state = S_DIV;
                else n_state = S_DONE;
            end
            S_DIV: begin
                if (r_cnt == '0) n_state = S_UPDATE;
            end
            S_UPDATE: n_state = S_CHECK;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // bit counter
    always_comb begin
        n_cnt = r_cnt;
        case (r_state)
            S_CHECK: n_cnt = CNT_W'(WIDTH - 1);
            S_DIV: begin
                if (r_cnt != '0) n_cnt = r_cnt - CNT_W'(1);
            end
            default: n_cnt = r_cnt;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start;
            end
            S_CHECK: begin
                o_cmd.div_init = !i_sts.m_one && i_sts.a_gt1 && !i_sts.n_zero;
            end
            S_DIV:    o_cmd.div_step = 1'b1;
            S_UPDATE: o_cmd.update   = 1'b1;
            S_DONE:   o_cmd.fin      = 1'b1;
            default:  o_cmd = '0;
        endcase
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd))
        else $error("more than one datapath command");

    a_div_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == '0) |=> (r_state == S_UPDATE))
        else $error("division did not end after last bit");

    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_CHECK))
        else $error("accepted item did not start a step");

endmodule

// ===== rtl/mie_dp.sv =====
// Datapath: Euclid pair, restoring divider, coefficient update, result register.
module mie_dp
    import mie_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_in     i_data,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output logic    o_strobe,
    output t_out    o_result
);

    logic [WIDTH-1:0] r_a, r_n, r_m, r_rem;
    logic [CW-1:0]    r_cprev, r_ccur, r_prod;
    logic             r_strobe;
    t_out             r_result;

    logic [WIDTH:0]   trial;
    logic             ge;
    logic [WIDTH:0]   diff;
    logic [CW-1:0]    c_fix;
    t_out             res;

    // one restoring division bit
    assign trial = {r_rem, r_a[WIDTH-1]};
    assign ge    = trial >= {1'b0, r_n};
    assign diff  = trial - {1'b0, r_n};

    assign o_sts.a_gt1  = r_a > WIDTH'(1);
    assign o_sts.n_zero = r_n == '0;
    assign o_sts.m_one  = r_m == WIDTH'(1);

    // negative coefficient gets the modulus added once
    assign c_fix = r_ccur[CW-1] ? r_ccur + {2'b00, r_m} : r_ccur;

    always_comb begin
        res = '0;
        if (o_sts.m_one) begin
            res.exists  = 1'b1;
            res.inverse = WIDTH'(1);
        end else if (r_a == WIDTH'(1)) begin
            res.exists  = 1'b1;
            res.inverse = c_fix[WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a     <= i_data.value;
            r_n     <= i_data.modulus;
            r_m     <= i_data.modulus;
            r_cprev <= '0;
            r_ccur  <= CW'(1);
        end else if (i_cmd.div_init) begin
            r_rem  <= '0;
            r_prod <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
            r_a    <= {r_a[WIDTH-2:0], ge};
            r_prod <= {r_prod[CW-2:0], 1'b0} + (ge ? r_cprev : '0);
        end else if (i_cmd.update) begin
            r_a     <= r_n;
            r_n     <= r_rem;
            r_cprev <= r_ccur - r_prod;
            r_ccur  <= r_cprev;
        end
        if (i_cmd.fin) r_result <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strobe <= 1'b0;
        else          r_strobe <= i_cmd.fin;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> $past(i_cmd.fin))
        else $error("result strobe without finish command");

    a_no_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_result.exists) |-> (r_result.inverse == '0))
        else $error("inverse nonzero when none exists");

endmodule

// ===== rtl/modular_inverse_ext_euclid.sv =====
// Top level: modular inverse by the iterative extended Euclidean algorithm.
// The number of Euclid steps per item depends on the operands (up to about 46 at 31 bits).
// Each step is a CHECK state, the one-bit restoring divider stepped through all WIDTH quotient bits
//   (quotient times coefficient is accumulated in the same pass), and an UPDATE state.
// One item at a time; busy is low from the strobe cycle on, results cannot stall.
// Reset (synchronous, active low) returns the controller to idle and drops the strobe.
module modular_inverse_ext_euclid
    import mie_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_data,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequencing: idle, check loop condition, divide, update, finish
    mie_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // operand registers, divider, coefficient pair and result register
    mie_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_data   (i_data),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

// ===== sim/tb.sv =====
// Testbench for modular_inverse_ext_euclid: directed and random items against a predictor.
module tb;
    import mie_pkg::*;

    // Cycles with no accept and no strobe before the run is declared hung.
    localparam int HANG_LIMIT = 20000;
    localparam logic [WIDTH-1:0] MAX_VAL = {WIDTH{1'b1}};
    // Consecutive Fibonacci numbers below 2^31: the longest Euclid chain.
    localparam logic [WIDTH-1:0] FIB_LO = 31'd1134903170;
    localparam logic [WIDTH-1:0] FIB_HI = 31'd1836311903;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_data;
    logic busy;
    logic o_strobe;
    t_out o_result;

    t_out expected_inverses[$];

    int n_items = 0;
    int n_results = 0;
    int n_exists = 0;
    int n_none = 0;
    int n_mismatch = 0;
    int n_unexpected = 0;
    int idle_cycles = 0;
    bit burst_mode;

    modular_inverse_ext_euclid dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_data   (i_data),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Extended Euclid with signed Bezout coefficient of the value.
    function automatic t_out predict_inverse(input t_in item);
        longint unsigned a;
        longint unsigned n;
        longint unsigned m;
        longint unsigned q;
        longint unsigned r;
        longint unsigned x;
        longint unsigned y;
        longint c_prev;
        longint c_cur;
        longint t;
        t_out res;
        a = item.value;
        n = item.modulus;
        m = n;
        res = '0;
        x = a;
        y = n;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        if (x != 1)
            return res;
        res.exists = 1'b1;
        if (n == 1) begin
            res.inverse = WIDTH'(1);
            return res;
        end
        c_prev = 0;
        c_cur = 1;
        while (a > 1 && n != 0) begin
            q = a / n;
            r = a % n;
            t = c_prev;
            a = n;
            n = r;
            c_prev = c_cur - longint'(q) * c_prev;
            c_cur = t;
        end
        if (c_cur < 0)
            c_cur += longint'(m);
        res.inverse = c_cur[WIDTH-1:0];
        return res;
    endfunction

    // Result check first, then capture of a newly accepted item.
    always @(posedge i_clk) begin
        t_out want;
        bit   progress;
        if (i_rst_n) begin
            progress = 1'b0;
            if (o_strobe) begin
                progress = 1'b1;
                n_results++;
                if (o_result.exists)
                    n_exists++;
                else
                    n_none++;
                if (expected_inverses.size() == 0) begin
                    n_unexpected++;
                    $display("unexpected result: exists=%0b inverse=%0d",
                             o_result.exists, o_result.inverse);
                end else begin
                    want = expected_inverses.pop_front();
                    if (o_result.exists !== want.exists ||
                        o_result.inverse !== want.inverse) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display("mismatch: exists exp %0b got %0b, inverse exp %0d got %0d",
                                     want.exists, o_result.exists,
                                     want.inverse, o_result.inverse);
                    end
                end
            end
            if (start && !busy) begin
                progress = 1'b1;
                n_items++;
                expected_inverses.push_back(predict_inverse(i_data));
            end
            if (progress)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("timeout: no progress for %0d cycles", HANG_LIMIT);
                $display("status: fail");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (burst_mode || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(20, 200);
    endfunction

    // Start stays high across back-to-back items; it drops only for a gap or in wait_all_results.
    task automatic send_item(input logic [WIDTH-1:0] value,
                             input logic [WIDTH-1:0] modulus, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_data <= '{value: value, modulus: modulus};
        do @(posedge i_clk); while (busy);
    endtask

    task automatic wait_all_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_inverses.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic test_special_cases();
        send_item(0, 0, pick_gap());            // both zero
        send_item(1, 0, pick_gap());            // modulus zero, value one
        send_item(5, 0, pick_gap());            // modulus zero, no inverse
        send_item(0, 1, pick_gap());            // modulus one, value zero
        send_item(MAX_VAL, 1, pick_gap());      // modulus one, max value
        send_item(0, 7, pick_gap());            // value zero
        send_item(0, MAX_VAL, pick_gap());
        send_item(2, 4, pick_gap());            // shared factor
        send_item(13, 13, pick_gap());          // equal operands
        send_item(1, 1, pick_gap());
    endtask

    task automatic test_field_extremes();
        send_item(3, 7, pick_gap());
        send_item(100, 7, pick_gap());          // value above modulus
        send_item(MAX_VAL, 7, pick_gap());
        send_item(MAX_VAL, MAX_VAL, pick_gap());
        send_item(MAX_VAL, MAX_VAL - 1, pick_gap());
        send_item(MAX_VAL - 1, MAX_VAL, pick_gap());
        send_item(1, MAX_VAL, pick_gap());
        send_item(1, 2, pick_gap());
        send_item(31'h2AAA_AAAA, 31'h5555_5555, pick_gap());
    endtask

    task automatic test_longest_chain();
        send_item(FIB_LO, FIB_HI, 0);
        send_item(FIB_HI, FIB_LO, 0);
        send_item(FIB_HI - FIB_LO, FIB_LO, pick_gap());
    endtask

    task automatic test_random_items(input int count);
        logic [WIDTH-1:0] v;
        logic [WIDTH-1:0] m;
        logic [WIDTH-1:0] d;
        int kind;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            kind = $urandom_range(0, 9);
            v = WIDTH'($urandom());
            m = WIDTH'($urandom());
            case (kind)
                6: begin
                    v = WIDTH'($urandom_range(0, 999));
                    m = WIDTH'($urandom_range(0, 999));
                end
                7: begin
                    m = WIDTH'($urandom()) | 31'd1;
                    v = WIDTH'($urandom_range(0, m));
                end
                8: begin
                    // operand edges mixed with random content
                    case ($urandom_range(0, 5))
                        0: v = 0;
                        1: v = 1;
                        2: v = MAX_VAL;
                        3: m = 0;
                        4: m = 1;
                        default: m = MAX_VAL;
                    endcase
                end
                9: begin
                    // common factor of at least two: never invertible
                    d = WIDTH'($urandom_range(2, 5000));
                    v = WIDTH'(d * WIDTH'($urandom_range(0, 400000)));
                    m = WIDTH'(d * WIDTH'($urandom_range(1, 400000)));
                end
                default: ;
            endcase
            if ($urandom_range(0, 49) == 0)
                wait_all_results();
            send_item(v, m, pick_gap());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_data = '0;
        burst_mode = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_special_cases();
        test_field_extremes();
        wait_all_results();
        test_longest_chain();
        test_random_items(400);

        wait_all_results();
        repeat (50) @(posedge i_clk);

        if (expected_inverses.size() != 0)
            $display("%0d results never arrived", expected_inverses.size());
        $display("covered %0d items: %0d with an inverse, %0d without",
                 n_items, n_exists, n_none);
        $display("mismatches %0d, unexpected results %0d", n_mismatch, n_unexpected);
        if (n_mismatch == 0 && n_unexpected == 0 && expected_inverses.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
